// ----- rtl/pac_pkg.sv -----
package pac_pkg;

  // Input and accumulator widths
  localparam int COORD_W      = 16;
  localparam int MAX_VERTICES = 1024;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W        = COORD_W + 1;
  localparam int CROSS_W      = 2 * COORD_W + 1;
  localparam int MPROD_W      = SUM_W + CROSS_W;
  localparam int AREA_W       = 43;
  localparam int MOM_W        = 60;
  localparam int OUT_AREA_W   = 42;

  // Divider widths
  localparam int DIV_W   = AREA_W + 2;
  localparam int Q_BITS  = 18;
  localparam int SH_W    = DIV_W + Q_BITS - 1;
  localparam int ITER_W  = $clog2(Q_BITS + 1);
  localparam int CEN_W   = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One finished polygon, waiting for the divide
  typedef struct packed {
    logic signed [AREA_W-1:0] area;
    logic signed [MOM_W-1:0]  mom_x;
    logic signed [MOM_W-1:0]  mom_y;
    logic                     ovf;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/pac_front.sv -----
module pac_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pac_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [pac_pkg::COORD_W-1:0] in_vertex_y,
  input  logic                              in_last_vertex,
  output logic                              push,
  output pac_pkg::job_t                     push_job,
  input  pac_pkg::qstat_t                   qstat
);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_PROD  = 6'b000010,
    F_CROSS = 6'b000100,
    F_MOM   = 6'b001000,
    F_ACC   = 6'b010000,
    F_PUSH  = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [pac_pkg::COORD_W-1:0]   first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [pac_pkg::COORD_W-1:0]   ax_r, ay_r, bx_r, by_r;
  logic [pac_pkg::CNT_W-1:0]            count_r;
  logic                                 ovf_r, last_r, close_r;
  logic signed [2*pac_pkg::COORD_W-1:0] p1_r, p2_r;
  logic signed [pac_pkg::SUM_W-1:0]     sx_r, sy_r;
  logic signed [pac_pkg::CROSS_W-1:0]   cross_r;
  logic signed [pac_pkg::MPROD_W-1:0]   mxp_r, myp_r;
  logic signed [pac_pkg::AREA_W-1:0]    area_r;
  logic signed [pac_pkg::MOM_W-1:0]     momx_r, momy_r;
  logic                                 accept, full_cnt;

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full_cnt = (count_r >= pac_pkg::CNT_W'(pac_pkg::MAX_VERTICES));

  assign push              = (state_r == F_PUSH) && !qstat.full;
  assign push_job.area     = area_r;
  assign push_job.mom_x    = momx_r;
  assign push_job.mom_y    = momy_r;
  assign push_job.ovf      = ovf_r;

  // Control sequence: one edge goes through product, cross, moment, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
      close_r <= 1'b0;
      area_r  <= '0;
      momx_r  <= '0;
      momy_r  <= '0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            last_r  <= in_last_vertex;
            if (full_cnt) begin
              ovf_r   <= 1'b1;
              close_r <= 1'b0;
            end else begin
              close_r  <= in_last_vertex && !ovf_r;
              prev_x_r <= in_vertex_x;
              prev_y_r <= in_vertex_y;
              count_r  <= count_r + 1'b1;
              if (count_r == '0) begin
                first_x_r <= in_vertex_x;
                first_y_r <= in_vertex_y;
              end
            end
          end
        end
        F_ACC: begin
          area_r <= area_r + pac_pkg::AREA_W'(cross_r);
          momx_r <= momx_r + pac_pkg::MOM_W'(mxp_r);
          momy_r <= momy_r + pac_pkg::MOM_W'(myp_r);
          if (close_r) close_r <= 1'b0;
        end
        F_PUSH: begin
          if (!qstat.full) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
            area_r  <= '0;
            momx_r  <= '0;
            momy_r  <= '0;
            first_x_r <= '0;
            first_y_r <= '0;
            prev_x_r  <= '0;
            prev_y_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Edge datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (accept && !full_cnt && count_r != '0) begin
          ax_r <= prev_x_r;
          ay_r <= prev_y_r;
          bx_r <= in_vertex_x;
          by_r <= in_vertex_y;
        end else if (accept && !full_cnt) begin
          ax_r <= in_vertex_x;
          ay_r <= in_vertex_y;
          bx_r <= in_vertex_x;
          by_r <= in_vertex_y;
        end else if (accept) begin
          ax_r <= prev_x_r;
          ay_r <= prev_y_r;
          bx_r <= first_x_r;
          by_r <= first_y_r;
        end
      end
      F_PROD: begin
        p1_r <= ax_r * by_r;
        p2_r <= ay_r * bx_r;
        sx_r <= pac_pkg::SUM_W'(ax_r) + pac_pkg::SUM_W'(bx_r);
        sy_r <= pac_pkg::SUM_W'(ay_r) + pac_pkg::SUM_W'(by_r);
      end
      F_CROSS: cross_r <= pac_pkg::CROSS_W'(p1_r) - pac_pkg::CROSS_W'(p2_r);
      F_MOM: begin
        mxp_r <= pac_pkg::MPROD_W'(sx_r) * pac_pkg::MPROD_W'(cross_r);
        myp_r <= pac_pkg::MPROD_W'(sy_r) * pac_pkg::MPROD_W'(cross_r);
      end
      F_ACC: begin
        // closing edge back to the first vertex
        if (close_r) begin
          ax_r <= prev_x_r;
          ay_r <= prev_y_r;
          bx_r <= first_x_r;
          by_r <= first_y_r;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (full_cnt) state_nxt = in_last_vertex ? F_PUSH : F_IDLE;
          else if (count_r != '0 || (in_last_vertex && !ovf_r)) state_nxt = F_PROD;
          else state_nxt = in_last_vertex ? F_PUSH : F_IDLE;
        end
      end
      F_PROD:  state_nxt = F_CROSS;
      F_CROSS: state_nxt = F_MOM;
      F_MOM:   state_nxt = F_ACC;
      F_ACC: begin
        priority if (close_r) state_nxt = F_PROD;
        else if (last_r)      state_nxt = F_PUSH;
        else                  state_nxt = F_IDLE;
      end
      F_PUSH:  state_nxt = qstat.full ? F_PUSH : F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

// ----- rtl/pac_queue.sv -----
module pac_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pac_pkg::job_t    push_job,
  input  logic             pop,
  output pac_pkg::job_t    head_job,
  output pac_pkg::qstat_t  qstat
);

  pac_pkg::job_t                   slot_r [pac_pkg::QUEUE_DEPTH];
  logic [pac_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [pac_pkg::QCNT_W-1:0]      cnt_r;

  assign qstat.full  = (cnt_r == pac_pkg::QCNT_W'(pac_pkg::QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head_job    = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- rtl/pac_back.sv -----
module pac_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pac_pkg::job_t                          head_job,
  input  pac_pkg::qstat_t                        qstat,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pac_pkg::OUT_AREA_W-1:0]  out_twice_signed_area,
  output logic signed [pac_pkg::CEN_W-1:0]       out_centroid_x,
  output logic signed [pac_pkg::CEN_W-1:0]       out_centroid_y,
  output logic                                   out_degenerate,
  output logic                                   out_too_many_vertices
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_PREP = 4'b0010,
    B_DIV  = 4'b0100,
    B_DONE = 4'b1000
  } bstate_t;

  bstate_t state_r;

  pac_pkg::job_t                    job_r;
  logic                             zero_r, negx_r, negy_r;
  logic [pac_pkg::MOM_W-1:0]        remx_r, remy_r;
  logic [pac_pkg::SH_W-1:0]         dsh_r;
  logic [pac_pkg::Q_BITS-1:0]       qx_r, qy_r;
  logic [pac_pkg::ITER_W-1:0]       iter_r;
  logic                             out_valid_r;
  logic signed [pac_pkg::DIV_W-1:0] div3;
  logic [pac_pkg::DIV_W-1:0]        dmag;
  logic [pac_pkg::MOM_W-1:0]        nxmag, nymag;
  logic                             gex, gey;
  logic [pac_pkg::SH_W-1:0]         subx, suby;

  // Saturate a quotient magnitude to a signed 16-bit result
  function automatic logic [pac_pkg::CEN_W-1:0] sat_q(
    input logic [pac_pkg::Q_BITS-1:0] q, input logic neg);
    logic [pac_pkg::Q_BITS-1:0] lim;
    logic [pac_pkg::Q_BITS-1:0] qs;
    lim = neg ? pac_pkg::Q_BITS'(32768) : pac_pkg::Q_BITS'(32767);
    qs  = (q > lim) ? lim : q;
    if (neg) qs = -qs;
    return qs[pac_pkg::CEN_W-1:0];
  endfunction

  assign out_valid = out_valid_r;
  assign pop       = (state_r == B_IDLE) && !qstat.empty && !out_valid_r;

  // Divisor is three times the doubled area; operands go to magnitudes
  assign div3  = (pac_pkg::DIV_W'(job_r.area) <<< 1) + pac_pkg::DIV_W'(job_r.area);
  assign dmag  = div3[pac_pkg::DIV_W-1] ? pac_pkg::DIV_W'(-div3) : pac_pkg::DIV_W'(div3);
  assign nxmag = job_r.mom_x[pac_pkg::MOM_W-1] ? pac_pkg::MOM_W'(-job_r.mom_x)
                                               : pac_pkg::MOM_W'(job_r.mom_x);
  assign nymag = job_r.mom_y[pac_pkg::MOM_W-1] ? pac_pkg::MOM_W'(-job_r.mom_y)
                                               : pac_pkg::MOM_W'(job_r.mom_y);

  // One restoring step per cycle on each axis
  assign gex  = pac_pkg::SH_W'(remx_r) >= dsh_r;
  assign gey  = pac_pkg::SH_W'(remy_r) >= dsh_r;
  assign subx = pac_pkg::SH_W'(remx_r) - dsh_r;
  assign suby = pac_pkg::SH_W'(remy_r) - dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: if (pop) state_r <= B_PREP;
        B_PREP: begin
          iter_r  <= '0;
          state_r <= (job_r.ovf || job_r.area == '0) ? B_DONE : B_DIV;
        end
        B_DIV: begin
          iter_r <= iter_r + 1'b1;
          if (iter_r == pac_pkg::ITER_W'(pac_pkg::Q_BITS - 1)) state_r <= B_DONE;
        end
        B_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Job and divider datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: if (pop) job_r <= head_job;
      B_PREP: begin
        zero_r <= (job_r.area == '0);
        negx_r <= job_r.mom_x[pac_pkg::MOM_W-1] ^ div3[pac_pkg::DIV_W-1];
        negy_r <= job_r.mom_y[pac_pkg::MOM_W-1] ^ div3[pac_pkg::DIV_W-1];
        remx_r <= nxmag;
        remy_r <= nymag;
        dsh_r  <= pac_pkg::SH_W'(dmag) << (pac_pkg::Q_BITS - 1);
        qx_r   <= '0;
        qy_r   <= '0;
      end
      B_DIV: begin
        if (gex) remx_r <= subx[pac_pkg::MOM_W-1:0];
        if (gey) remy_r <= suby[pac_pkg::MOM_W-1:0];
        qx_r  <= {qx_r[pac_pkg::Q_BITS-2:0], gex};
        qy_r  <= {qy_r[pac_pkg::Q_BITS-2:0], gey};
        dsh_r <= dsh_r >> 1;
      end
      B_DONE: begin
        out_too_many_vertices <= job_r.ovf;
        if (job_r.ovf) begin
          out_twice_signed_area <= '0;
          out_centroid_x        <= '0;
          out_centroid_y        <= '0;
          out_degenerate        <= 1'b0;
        end else begin
          out_twice_signed_area <= job_r.area[pac_pkg::OUT_AREA_W-1:0];
          out_degenerate        <= zero_r;
          out_centroid_x        <= zero_r ? '0 : sat_q(qx_r, negx_r);
          out_centroid_y        <= zero_r ? '0 : sat_q(qy_r, negy_r);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/polygon_area_centroid.sv -----
// Channel  Direction  Ports
// in_      input      in_valid, in_stall, in_vertex_x, in_vertex_y, in_last_vertex
// out_     output     out_valid, out_stall, out_twice_signed_area, out_centroid_x,
//                     out_centroid_y, out_degenerate, out_too_many_vertices
//
// In the front, each vertex after the first goes through a four-step edge chain
// (product, cross, moment, accumulate); the first vertex of a polygon and a vertex
// past the limit skip it. A last vertex then runs the closing edge through the chain
// and the polygon enters the queue, waiting while the queue is full.
// The back pops a job, sets up, runs 18 restoring-divide steps, loads the result;
// an overflowed or zero-area polygon skips the divide. Output stalls hold the back.
// A two-entry queue lets the front keep taking vertices while the back divides.
// Reset is synchronous, active low, and clears control state and front accumulators.
module polygon_area_centroid (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pac_pkg::COORD_W-1:0]     in_vertex_x,
  input  logic signed [pac_pkg::COORD_W-1:0]     in_vertex_y,
  input  logic                                   in_last_vertex,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pac_pkg::OUT_AREA_W-1:0]  out_twice_signed_area,
  output logic signed [pac_pkg::CEN_W-1:0]       out_centroid_x,
  output logic signed [pac_pkg::CEN_W-1:0]       out_centroid_y,
  output logic                                   out_degenerate,
  output logic                                   out_too_many_vertices
);

  logic            push, pop;
  pac_pkg::job_t   push_job, head_job;
  pac_pkg::qstat_t qstat;

  pac_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_vertex_x, .in_vertex_y, .in_last_vertex,
    .push, .push_job, .qstat
  );

  pac_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .head_job, .qstat
  );

  pac_back u_back (
    .clk, .rst_n, .head_job, .qstat, .pop, .out_valid, .out_stall,
    .out_twice_signed_area, .out_centroid_x, .out_centroid_y,
    .out_degenerate, .out_too_many_vertices
  );

endmodule
